// ===== sv/pus_pkg.sv =====
// ----------------------------------------------------------------------------
// pus_pkg
// Shared sizes, codes and controller interface types of the peer unchoke
// selector.
// ----------------------------------------------------------------------------
package pus_pkg;

   // table size and derived widths
   localparam int PEER_SLOTS = 16;
   localparam int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W      = $clog2(PEER_SLOTS + 1);

   // transaction field widths
   localparam int CMD_W      = 2;
   localparam int ID_W       = 31;
   localparam int SLOT_W     = 4;
   localparam int REQS_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int MASK_W     = 16;
   localparam int TOTAL_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [REQS_W-1:0]     reqs_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam idx_type LAST_IDX = IDX_W'(PEER_SLOTS - 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_PEERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_COUNT      = 2'd1;

   localparam csr_data_type TOP_COUNT_RESET = 5'd4;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 5'd31;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UPDATE     = 2'd1,
      CMD_SELECT     = 2'd2,
      CMD_OPTIMISTIC = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_AWAIT = 2'd1,
      STATUS_NONE  = 2'd2,
      STATUS_BAD   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_SCAN,
      ST_PICK,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_init;
      logic scan_step;
      logic pick;
      logic finish;
      logic load_out;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic select_go;
      logic limit_hit;
      logic scan_last;
      logic best_found;
      logic out_free;
   } ctl_stat_type;

endpackage

// ===== sv/pus_ctrl.sv =====
// ----------------------------------------------------------------------------
// pus_ctrl
// Sequencer of the peer unchoke selector: takes a transaction, runs the
// command and, for a select tick, repeats table scans until the limit is met
// or nothing eligible remains.
// ----------------------------------------------------------------------------
module pus_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pus_pkg::ctl_stat_type stat,
   output pus_pkg::ctl_cmd_type  cmd
);
   import pus_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.select_go ? ST_CHECK : ST_DONE;
         end
         ST_CHECK: begin
            state_in = stat.limit_hit ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = stat.best_found ? ST_CHECK : ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_CHECK: begin
            cmd.finish    = stat.limit_hit;
            cmd.scan_init = !stat.limit_hit;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_PICK: begin
            cmd.pick   = stat.best_found;
            cmd.finish = !stat.best_found;
         end
         ST_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/pus_datapath.sv =====
// ----------------------------------------------------------------------------
// pus_datapath
// Peer table, configuration registers, request capture, max-count scan
// and the result register of the peer unchoke selector.
// ----------------------------------------------------------------------------
module pus_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pus_pkg::CMD_W-1:0]       req_command,
   input  logic [pus_pkg::SLOT_W-1:0]      req_slot,
   input  logic [pus_pkg::REQS_W-1:0]      req_request_count,
   input  logic                            req_is_choked,
   input  logic                            req_is_interested,
   input  logic                            req_is_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pus_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pus_pkg::CSR_DATA_W-1:0]  csr_data,
   input  pus_pkg::ctl_cmd_type            cmd,
   output pus_pkg::ctl_stat_type           stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pus_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_keep_running,
   output logic [pus_pkg::SLOT_W-1:0]      rsp_assigned_slot,
   output logic [pus_pkg::MASK_W-1:0]      rsp_unchoked_mask,
   output logic [pus_pkg::TOTAL_W-1:0]     rsp_unchoked_total
);
   import pus_pkg::*;

   // captured transaction
   command_type        cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   reqs_type           count_ff, count_in;
   logic               choked_bit_ff, choked_bit_in;
   logic               interested_bit_ff, interested_bit_in;
   logic               done_bit_ff, done_bit_in;

   // configuration and registration state
   csr_data_type       awaited_ff, awaited_in;
   csr_data_type       top_ff, top_in;
   cnt_type            reg_total_ff, reg_total_in;

   // peer table
   logic [PEER_SLOTS-1:0] valid_ff, valid_in;
   logic [PEER_SLOTS-1:0] choked_ff, choked_in;
   logic [PEER_SLOTS-1:0] interested_ff, interested_in;
   logic [PEER_SLOTS-1:0] done_ff, done_in;
   reqs_type              count_tab_ff [PEER_SLOTS];
   reqs_type              count_tab_in [PEER_SLOTS];

   // scan state
   idx_type            idx_ff, idx_in;
   idx_type            best_ff, best_in;
   reqs_type           best_cnt_ff, best_cnt_in;
   logic               found_ff, found_in;
   cnt_type            picked_ff, picked_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;

   // pending result
   status_type         res_status_ff, res_status_in;
   logic               res_keep_ff, res_keep_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         out_status_ff, out_status_in;
   logic               out_keep_ff, out_keep_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [MASK_W-1:0]  out_mask_ff, out_mask_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;

   idx_type               slot_idx;
   idx_type               reg_idx;
   logic                  slot_ok;
   logic                  table_full;
   logic [PEER_SLOTS-1:0] eligible;
   logic                  any_live;

   assign csr_ready  = 1'b1;
   assign slot_idx   = IDX_W'(slot_ff);
   assign reg_idx    = IDX_W'(reg_total_ff);
   assign slot_ok    = (32'(slot_ff) < 32'(PEER_SLOTS)) && valid_ff[slot_idx];
   assign table_full = (32'(reg_total_ff) >= 32'(PEER_SLOTS));
   assign eligible   = valid_ff & choked_ff & interested_ff & ~done_ff;
   assign any_live   = |(valid_ff & ~done_ff);

   assign stat.select_go  = (cmd_ff == CMD_SELECT) && (awaited_ff == '0) && any_live;
   assign stat.limit_hit  = (top_ff != '0) && (32'(picked_ff) >= 32'(top_ff));
   assign stat.scan_last  = (idx_ff == LAST_IDX);
   assign stat.best_found = found_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd_in            = cmd_ff;
      slot_in           = slot_ff;
      count_in          = count_ff;
      choked_bit_in     = choked_bit_ff;
      interested_bit_in = interested_bit_ff;
      done_bit_in       = done_bit_ff;
      awaited_in        = awaited_ff;
      top_in            = top_ff;
      reg_total_in      = reg_total_ff;
      valid_in          = valid_ff;
      choked_in         = choked_ff;
      interested_in     = interested_ff;
      done_in           = done_ff;
      count_tab_in      = count_tab_ff;
      idx_in            = idx_ff;
      best_in           = best_ff;
      best_cnt_in       = best_cnt_ff;
      found_in          = found_ff;
      picked_in         = picked_ff;
      mask_in           = mask_ff;
      res_status_in     = res_status_ff;
      res_keep_in       = res_keep_ff;
      res_slot_in       = res_slot_ff;
      rsp_valid_in      = rsp_valid_ff;
      out_status_in     = out_status_ff;
      out_keep_in       = out_keep_ff;
      out_slot_in       = out_slot_ff;
      out_mask_in       = out_mask_ff;
      out_total_in      = out_total_ff;

      // writing expected_peers sets the count of awaited registrations
      if (csr_valid) begin
         if (csr_index == CSR_EXPECTED_PEERS) begin
            awaited_in = csr_data;
         end else if (csr_index == CSR_TOP_COUNT) begin
            top_in = csr_data;
         end
      end

      if (cmd.capture) begin
         cmd_in            = command_type'(req_command);
         slot_in           = req_slot;
         count_in          = req_request_count;
         choked_bit_in     = req_is_choked;
         interested_bit_in = req_is_interested;
         done_bit_in       = req_is_done;
      end

      if (cmd.exec) begin
         res_status_in = STATUS_OK;
         res_keep_in   = 1'b1;
         res_slot_in   = '0;
         mask_in       = '0;
         picked_in     = '0;
         case (cmd_ff)
            CMD_REGISTER: begin
               if (table_full) begin
                  res_status_in = STATUS_BAD;
               end else begin
                  count_tab_in[reg_idx]  = '0;
                  choked_in[reg_idx]     = 1'b0;
                  interested_in[reg_idx] = 1'b0;
                  done_in[reg_idx]       = 1'b0;
                  valid_in[reg_idx]      = 1'b1;
                  res_slot_in            = SLOT_W'(reg_total_ff);
                  reg_total_in           = reg_total_ff + CNT_W'(1);
                  // saturate at zero
                  if (awaited_ff != '0) awaited_in = awaited_ff - CSR_DATA_W'(1);
               end
            end
            CMD_UPDATE: begin
               if (!slot_ok) begin
                  res_status_in = STATUS_BAD;
               end else begin
                  count_tab_in[slot_idx]  = count_ff;
                  choked_in[slot_idx]     = choked_bit_ff;
                  interested_in[slot_idx] = interested_bit_ff;
                  done_in[slot_idx]       = done_bit_ff;
               end
            end
            CMD_SELECT: begin
               if (awaited_ff != '0) begin
                  res_status_in = STATUS_AWAIT;
               end else if (!any_live) begin
                  res_status_in = STATUS_NONE;
                  res_keep_in   = 1'b0;
               end
            end
            CMD_OPTIMISTIC: begin
               if (awaited_ff != '0) begin
                  res_status_in = STATUS_AWAIT;
               end else if (!slot_ok) begin
                  res_status_in = STATUS_BAD;
               end else if (eligible[slot_idx]) begin
                  choked_in[slot_idx] = 1'b0;
                  mask_in[slot_ff]    = 1'b1;
                  picked_in           = CNT_W'(1);
               end else begin
                  res_status_in = STATUS_NONE;
               end
            end
            default: begin
               res_status_in = STATUS_BAD;
            end
         endcase
      end

      if (cmd.scan_init) begin
         idx_in   = '0;
         found_in = 1'b0;
      end

      // strict compare keeps the earlier slot on a tie
      if (cmd.scan_step) begin
         if (eligible[idx_ff] && (!found_ff || (count_tab_ff[idx_ff] > best_cnt_ff))) begin
            best_in     = idx_ff;
            best_cnt_in = count_tab_ff[idx_ff];
            found_in    = 1'b1;
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.pick) begin
         choked_in[best_ff] = 1'b0;
         for (int b = 0; b < MASK_W; b++) begin
            if (32'(best_ff) == b) mask_in[b] = 1'b1;
         end
         picked_in = picked_ff + CNT_W'(1);
      end

      if (cmd.finish) begin
         res_status_in = (picked_ff == '0) ? STATUS_NONE : STATUS_OK;
      end

      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_keep_in   = res_keep_ff;
         out_slot_in   = res_slot_ff;
         out_mask_in   = mask_ff;
         out_total_in  = (32'(picked_ff) > 32'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : TOTAL_W'(picked_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaited_ff    <= '0;
         top_ff        <= TOP_COUNT_RESET;
         reg_total_ff  <= '0;
         valid_ff      <= '0;
         choked_ff     <= '0;
         interested_ff <= '0;
         done_ff       <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         awaited_ff    <= awaited_in;
         top_ff        <= top_in;
         reg_total_ff  <= reg_total_in;
         valid_ff      <= valid_in;
         choked_ff     <= choked_in;
         interested_ff <= interested_in;
         done_ff       <= done_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      slot_ff           <= slot_in;
      count_ff          <= count_in;
      choked_bit_ff     <= choked_bit_in;
      interested_bit_ff <= interested_bit_in;
      done_bit_ff       <= done_bit_in;
      count_tab_ff      <= count_tab_in;
      idx_ff            <= idx_in;
      best_ff           <= best_in;
      best_cnt_ff       <= best_cnt_in;
      picked_ff         <= picked_in;
      mask_ff           <= mask_in;
      res_status_ff     <= res_status_in;
      res_keep_ff       <= res_keep_in;
      res_slot_ff       <= res_slot_in;
      out_status_ff     <= out_status_in;
      out_keep_ff       <= out_keep_in;
      out_slot_ff       <= out_slot_in;
      out_mask_ff       <= out_mask_in;
      out_total_ff      <= out_total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_keep_running   = out_keep_ff;
   assign rsp_assigned_slot  = out_slot_ff;
   assign rsp_unchoked_mask  = out_mask_ff;
   assign rsp_unchoked_total = out_total_ff;

endmodule

// ===== sv/peer_unchoke_selector_unit.sv =====
// ----------------------------------------------------------------------------
// peer_unchoke_selector_unit
// Choking selector over a table of peers: register, update, select tick and
// optimistic try, one response transaction per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transaction, rsp_* returns one response per
//   request, in order. csr_* writes expected_peers (index 0) or top_count
//   (index 1); csr_ready is always high, and writes belong between requests.
//   Register, update and optimistic try pass through the exec and done states
//   after the request is accepted in idle. A select tick walks the table once
//   per peer unchoked, one slot per cycle, plus a last walk that finds none
//   unless top_count stops it first; a tick that needs no walk goes from exec
//   straight to done.
//   One request is processed at a time. The next request is taken as soon as
//   the result has moved into the output register, even while rsp_ready is
//   low; a stalled response holds its output register and the next result
//   waits inside until the register frees.
//   Reset clears the table, the registration count, awaited registrations
//   (to 0) and sets top_count to 4; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module peer_unchoke_selector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pus_pkg::CMD_W-1:0]       req_command,
   input  logic [pus_pkg::ID_W-1:0]        req_peer_id,
   input  logic [pus_pkg::SLOT_W-1:0]      req_slot,
   input  logic [pus_pkg::REQS_W-1:0]      req_request_count,
   input  logic                            req_is_choked,
   input  logic                            req_is_interested,
   input  logic                            req_is_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pus_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pus_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pus_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_keep_running,
   output logic [pus_pkg::SLOT_W-1:0]      rsp_assigned_slot,
   output logic [pus_pkg::MASK_W-1:0]      rsp_unchoked_mask,
   output logic [pus_pkg::TOTAL_W-1:0]     rsp_unchoked_total
);
   import pus_pkg::*;

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   pus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd)
   );

   pus_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_slot           (req_slot),
      .req_request_count  (req_request_count),
      .req_is_choked      (req_is_choked),
      .req_is_interested  (req_is_interested),
      .req_is_done        (req_is_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (ctl_cmd),
      .stat               (ctl_stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_keep_running   (rsp_keep_running),
      .rsp_assigned_slot  (rsp_assigned_slot),
      .rsp_unchoked_mask  (rsp_unchoked_mask),
      .rsp_unchoked_total (rsp_unchoked_total)
   );

   // total and mask come from separate counters; they must agree
   a_total_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_unchoked_total) == $countones(rsp_unchoked_mask)))
      else $error("unchoked total disagrees with mask");

   a_await_unchokes_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_AWAIT)) |-> (rsp_unchoked_mask == '0))
      else $error("unchoke reported while registrations awaited");

   a_stop_means_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_keep_running) |-> (rsp_status == STATUS_NONE))
      else $error("keep_running low without nothing-eligible status");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule

// ===== bench/peer_unchoke_selector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_unchoke_selector_unit_tb
// Drives register, update, select and optimistic transactions into the
// selector, predicts every response from a local copy of the peer table and
// compares each response field by field, in order, under random idling.
// ----------------------------------------------------------------------------
module peer_unchoke_selector_unit_tb;
   import pus_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      status_type          status;
      logic                keep;
      logic [SLOT_W-1:0]   slot;
      logic [MASK_W-1:0]   mask;
      logic [TOTAL_W-1:0]  total;
   } unchoke_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = '0;
   logic [ID_W-1:0]       req_peer_id = '0;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [REQS_W-1:0]     req_request_count = '0;
   logic                  req_is_choked = 1'b0;
   logic                  req_is_interested = 1'b0;
   logic                  req_is_done = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_keep_running;
   logic [SLOT_W-1:0]     rsp_assigned_slot;
   logic [MASK_W-1:0]     rsp_unchoked_mask;
   logic [TOTAL_W-1:0]    rsp_unchoked_total;

   // local copy of the peer table and its settings
   int unsigned       cfg_top = 4;
   int unsigned       awaited = 0;
   int unsigned       slots_filled = 0;
   logic [REQS_W-1:0] slot_reqs [PEER_SLOTS];
   bit                slot_choked [PEER_SLOTS];
   bit                slot_interested [PEER_SLOTS];
   bit                slot_done [PEER_SLOTS];
   bit                slot_valid [PEER_SLOTS];

   unchoke_result_type pending_results [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;

   peer_unchoke_selector_unit dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   function automatic bit slot_eligible(int s);
      return slot_valid[s] && slot_choked[s] && slot_interested[s] && !slot_done[s];
   endfunction

   function automatic unchoke_result_type predict_unchoke(command_type cmd,
         logic [SLOT_W-1:0] slot, logic [REQS_W-1:0] reqs,
         logic choked, logic interested, logic is_done);
      unchoke_result_type res;
      int best;
      int picked;
      bit any_live;
      res.status = STATUS_OK;
      res.keep = 1'b1;
      res.slot = '0;
      res.mask = '0;
      res.total = '0;
      case (cmd)
         CMD_REGISTER: begin
            if (slots_filled >= PEER_SLOTS) begin
               res.status = STATUS_BAD;
            end else begin
               slot_reqs[slots_filled] = '0;
               slot_choked[slots_filled] = 1'b0;
               slot_interested[slots_filled] = 1'b0;
               slot_done[slots_filled] = 1'b0;
               slot_valid[slots_filled] = 1'b1;
               res.slot = SLOT_W'(slots_filled);
               slots_filled++;
               if (awaited > 0) awaited--;
            end
         end
         CMD_UPDATE: begin
            if (!slot_valid[slot]) begin
               res.status = STATUS_BAD;
            end else begin
               slot_reqs[slot] = reqs;
               slot_choked[slot] = choked;
               slot_interested[slot] = interested;
               slot_done[slot] = is_done;
            end
         end
         CMD_SELECT: begin
            if (awaited != 0) begin
               res.status = STATUS_AWAIT;
            end else begin
               any_live = 1'b0;
               for (int s = 0; s < PEER_SLOTS; s++)
                  if (slot_valid[s] && !slot_done[s]) any_live = 1'b1;
               if (!any_live) begin
                  res.status = STATUS_NONE;
                  res.keep = 1'b0;
               end else begin
                  picked = 0;
                  // one pick per pass, highest count first, ties to the lower slot
                  for (int n = 0; n < PEER_SLOTS; n++) begin
                     if (cfg_top == 0 || picked < cfg_top) begin
                        best = -1;
                        for (int s = 0; s < PEER_SLOTS; s++)
                           if (slot_eligible(s) &&
                               (best < 0 || slot_reqs[s] > slot_reqs[best]))
                              best = s;
                        if (best >= 0) begin
                           slot_choked[best] = 1'b0;
                           res.mask[best] = 1'b1;
                           picked++;
                        end
                     end
                  end
                  res.total = TOTAL_W'(picked);
                  if (picked == 0) res.status = STATUS_NONE;
               end
            end
         end
         default: begin
            if (awaited != 0) begin
               res.status = STATUS_AWAIT;
            end else if (!slot_valid[slot]) begin
               res.status = STATUS_BAD;
            end else if (slot_eligible(slot)) begin
               slot_choked[slot] = 1'b0;
               res.mask[slot] = 1'b1;
               res.total = TOTAL_W'(1);
            end else begin
               res.status = STATUS_NONE;
            end
         end
      endcase
      return res;
   endfunction

   task automatic send_item(command_type cmd, logic [ID_W-1:0] id,
         logic [SLOT_W-1:0] slot, logic [REQS_W-1:0] reqs,
         logic choked, logic interested, logic is_done);
      unchoke_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_peer_id <= id;
      req_slot <= slot;
      req_request_count <= reqs;
      req_is_choked <= choked;
      req_is_interested <= interested;
      req_is_done <= is_done;
      do @(posedge clock); while (!req_ready);
      predicted = predict_unchoke(cmd, slot, reqs, choked, interested, is_done);
      pending_results = {pending_results, predicted};
   endtask

   // drop valid and hold until every response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(int unsigned expected_peers, int unsigned top_count);
      csr_valid <= 1'b1;
      csr_index <= CSR_EXPECTED_PEERS;
      csr_data <= CSR_DATA_W'(expected_peers);
      do @(posedge clock); while (!csr_ready);
      awaited = expected_peers;
      csr_index <= CSR_TOP_COUNT;
      csr_data <= CSR_DATA_W'(top_count);
      do @(posedge clock); while (!csr_ready);
      cfg_top = top_count;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_items(int count);
      command_type       cmd;
      logic [SLOT_W-1:0] slot;
      logic [REQS_W-1:0] reqs;
      int                pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 10) cmd = CMD_REGISTER;
         else if (pick < 55) cmd = CMD_UPDATE;
         else if (pick < 75) cmd = CMD_SELECT;
         else cmd = CMD_OPTIMISTIC;
         // mostly aim at filled slots, now and then anywhere
         if (slots_filled > 0 && $urandom_range(99) < 85)
            slot = SLOT_W'($urandom_range(slots_filled - 1));
         else
            slot = SLOT_W'($urandom_range(15));
         case ($urandom_range(3))
            0: reqs = $urandom_range(7);
            1: reqs = $urandom;
            2: reqs = 32'hFFFF_FFFF - $urandom_range(3);
            default: reqs = $urandom_range(3);
         endcase
         send_item(cmd, ID_W'($urandom), slot, reqs, $urandom_range(99) < 70,
                   $urandom_range(99) < 70, $urandom_range(99) < 15);
      end
      wait_idle();
   endtask

   task automatic test_basic_commands();
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_OPTIMISTIC, '0, 4'd15, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_item(CMD_REGISTER, 31'h7FFF_FFFF, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_REGISTER, 31'h0, 4'hF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_item(CMD_UPDATE, '0, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_OPTIMISTIC, '0, 4'd1, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd1, 32'h0, 1'b1, 1'b1, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd0, 32'd5, 1'b1, 1'b1, 1'b1);
      send_item(CMD_OPTIMISTIC, '0, 4'd1, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd1, 32'h0, 1'b0, 1'b0, 1'b1);
      // every registered peer done now
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_OPTIMISTIC, '0, 4'd4, '0, 1'b0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_awaiting_registrations();
      write_config(16, 16);
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_OPTIMISTIC, '0, 4'd0, '0, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < 3; i++)
         send_item(CMD_REGISTER, ID_W'($urandom), '0, '0, 1'b0, 1'b0, 1'b0);
      send_item(CMD_UPDATE, '0, 4'd2, 32'd9, 1'b1, 1'b1, 1'b0);
      send_item(CMD_SELECT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_single_unchoke();
      send_idle_pct = 6;
      rsp_stall_pct = 81;
      write_config(3, 1);
      run_random_items(135);
   endtask

   task automatic test_random_unlimited();
      send_idle_pct = 81;
      rsp_stall_pct = 6;
      write_config(0, 0);
      run_random_items(135);
   endtask

   task automatic test_random_back_to_back();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_config(0, $urandom_range(2, 15));
      run_random_items(130);
   endtask

   task automatic report_mismatch(unchoke_result_type want, unchoke_result_type got);
      $display("mismatch exp/act st %0d/%0d keep %0d/%0d slot %0d/%0d mask %h/%h tot %0d/%0d",
               want.status, got.status, want.keep, got.keep,
               want.slot, got.slot, want.mask, got.mask,
               want.total, got.total);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin : check_response
         unchoke_result_type want;
         unchoke_result_type got;
         got = {rsp_status, rsp_keep_running, rsp_assigned_slot, rsp_unchoked_mask,
                rsp_unchoked_total};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response transaction: status %0d mask %h",
                        rsp_status, rsp_unchoked_mask);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= 10)
                  report_mismatch(want, got);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_basic_commands();
      test_awaiting_registrations();
      test_random_single_unchoke();
      test_random_unlimited();
      test_random_back_to_back();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
